/* rtl/core/bb3_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, widths and arithmetic helpers for the 3x3 rgb box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int CH_W      = 16;   // one color channel
  localparam int VSUM_W    = 18;   // sum of up to three channel values
  localparam int HSUM_W    = 20;   // sum of up to nine channel values
  localparam int POS_W     = 10;   // row / column field on the output
  localparam int CFG_W     = 11;   // image_size register
  localparam int OUT_W     = 72;   // output tdata, padded to bytes
  localparam int REC_SHIFT = 24;
  localparam int REC_W     = 22;
  localparam int PROD_W    = HSUM_W + REC_W;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd512;
  // ceil(2^24 / d), exact for every sum up to 9 * 65535
  localparam logic [REC_W-1:0] REC_DIV6 = 22'd2796203;
  localparam logic [REC_W-1:0] REC_DIV9 = 22'd1864136;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pix_t;

  typedef struct packed {
    logic [VSUM_W-1:0] blue;
    logic [VSUM_W-1:0] green;
    logic [VSUM_W-1:0] red;
  } vsum_t;

  typedef struct packed {
    logic [HSUM_W-1:0] blue;
    logic [HSUM_W-1:0] green;
    logic [HSUM_W-1:0] red;
  } hsum_t;

  typedef enum logic [1:0] {
    AREA_4,
    AREA_6,
    AREA_9
  } area_t;

  // position flags of one input pixel
  typedef struct packed {
    logic has_out;
    logic last_row;
    logic last_col;
    logic top_clip;
    logic left_clip;
  } win_flags_t;

  // control that travels with one result
  typedef struct packed {
    area_t           area;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic            last;
    logic            eof;
  } res_ctl_t;

  function automatic vsum_t pix_pair_sum(pix_t a, pix_t b);
    vsum_t s;
    s.red   = VSUM_W'(a.red)   + VSUM_W'(b.red);
    s.green = VSUM_W'(a.green) + VSUM_W'(b.green);
    s.blue  = VSUM_W'(a.blue)  + VSUM_W'(b.blue);
    return s;
  endfunction

  function automatic vsum_t vsum_pix_add(vsum_t a, pix_t b);
    vsum_t s;
    s.red   = a.red   + VSUM_W'(b.red);
    s.green = a.green + VSUM_W'(b.green);
    s.blue  = a.blue  + VSUM_W'(b.blue);
    return s;
  endfunction

  function automatic hsum_t hsum_of(vsum_t a, vsum_t b, vsum_t c, logic use_c);
    hsum_t s;
    vsum_t cc;
    cc = use_c ? c : '0;
    s.red   = HSUM_W'(a.red)   + HSUM_W'(b.red)   + HSUM_W'(cc.red);
    s.green = HSUM_W'(a.green) + HSUM_W'(b.green) + HSUM_W'(cc.green);
    s.blue  = HSUM_W'(a.blue)  + HSUM_W'(b.blue)  + HSUM_W'(cc.blue);
    return s;
  endfunction

  // truncated mean: shift for four, reciprocal multiply for six and nine
  function automatic logic [CH_W-1:0] area_mean(logic [HSUM_W-1:0] s, area_t a);
    logic [PROD_W-1:0] prod;
    logic [CH_W-1:0]   m;
    prod = '0;
    unique case (a)
      AREA_4: begin
        m = s[2 +: CH_W];
      end
      AREA_6: begin
        prod = PROD_W'(s) * PROD_W'(REC_DIV6);
        m    = prod[REC_SHIFT +: CH_W];
      end
      AREA_9: begin
        prod = PROD_W'(s) * PROD_W'(REC_DIV9);
        m    = prod[REC_SHIFT +: CH_W];
      end
      default: begin
        m = '0;
      end
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/box_blur_3x3_rgb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 mean filter over a square rgb image with 16-bit channels.
// ----------------------------------------------------------------------------
// usage
//   s_* stream: one pixel per beat in raster order, red/green/blue in tdata
//   m_* stream: one smoothed pixel per beat with its row and column; tlast
//     marks the final result caused by an input beat, tuser the bottom-right
//     pixel of the frame
//   cfg_*: image_size (width = height), always ready; a write restarts the
//     position at row 0, column 0; sizes below 2 act as 2, above MAX_DIM
//     as MAX_DIM; write only while the block is idle
//   path: an accepted pixel passes the read stage, the job slot and the
//     emitter result register before its results reach the output register
//   throughput: one pixel per cycle while m_tready stays high; one result per
//     cycle leaves the emitter, so along the last row each pixel (2 results)
//     holds the input back; row-end and frame-end extras hide behind no-result pixels
//   the first row gives no results; output (r-1,c-1) follows input (r,c)
//   reset: position to row 0 column 0, size 512, pipeline emptied; the row
//     memories need no clearing since only rows of the current frame are read
//   stall: the output register holds while m_tready is low; the pipeline
//     behind it keeps filling, then s_tready drops
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
  parameter int MAX_DIM = 1024
) (
  input  wire                                clk,
  input  wire                                rst,
  // config: image_size
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [bb3_pkg::CFG_W-1:0]          cfg_data,
  // pixels in
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [3*bb3_pkg::CH_W-1:0]         s_tdata,   // in_red, in_green, in_blue
  // pixels out
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // out_red, out_green, out_blue, out_row, out_col, zero pad
  output logic [bb3_pkg::OUT_W-1:0]          m_tdata,
  output logic                               m_tlast,   // last_of_run
  output logic                               m_tuser    // end_of_frame
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int CMP_W = (CNT_W + 1 > bb3_pkg::CFG_W) ? CNT_W + 1 : bb3_pkg::CFG_W;
  localparam int RESET_DIM = (MAX_DIM < 512) ? MAX_DIM : 512;
  localparam logic [CNT_W-1:0] RESET_LAST = CNT_W'(RESET_DIM - 1);
  localparam logic [CNT_W-1:0] MAX_LAST   = CNT_W'(MAX_DIM - 1);

  // position of the next input pixel, and the last index of the image
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_count;
  logic [CNT_W-1:0] last_idx;
  logic [CNT_W-1:0] last_idx_next;
  logic [CMP_W-1:0] cfg_ext;
  logic [CMP_W-1:0] cfg_m1;

  logic                s_accept;
  logic                cfg_write;
  logic                win_ready;
  bb3_pkg::pix_t       in_pix;
  bb3_pkg::win_flags_t in_flags;

  // row memory
  bb3_pkg::pix_t    rd_older;
  bb3_pkg::pix_t    rd_recent;
  logic             wr_en;
  logic [CNT_W-1:0] wr_addr;
  bb3_pkg::pix_t    wr_older;
  bb3_pkg::pix_t    wr_recent;

  // window -> emitter
  logic                job_valid;
  logic                job_done;
  bb3_pkg::vsum_t      job_top [3];
  bb3_pkg::vsum_t      job_bot [3];
  bb3_pkg::win_flags_t job_flags;
  logic [CNT_W-1:0]    job_row;
  logic [CNT_W-1:0]    job_col;

  // emitter -> output register
  logic              res_valid;
  logic              res_ready;
  bb3_pkg::hsum_t    res_sum;
  bb3_pkg::res_ctl_t res_ctl;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign s_tready  = win_ready;
  assign s_accept  = s_tvalid && s_tready;
  assign in_pix    = s_tdata;

  // clamp the written size into 2..MAX_DIM and keep size-1
  always_comb begin
    cfg_ext = CMP_W'(cfg_data);
    cfg_m1  = cfg_ext - CMP_W'(1);
    if (cfg_ext < CMP_W'(2)) begin
      last_idx_next = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_DIM)) begin
      last_idx_next = MAX_LAST;
    end else begin
      last_idx_next = cfg_m1[CNT_W-1:0];
    end
  end

  always_comb begin
    in_flags.has_out   = (row_count != '0) && (col_count != '0);
    in_flags.last_row  = row_count == last_idx;
    in_flags.last_col  = col_count == last_idx;
    in_flags.top_clip  = row_count < CNT_W'(2);
    in_flags.left_clip = col_count < CNT_W'(2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      last_idx  <= RESET_LAST;
    end else if (cfg_write) begin
      row_count <= '0;
      col_count <= '0;
      last_idx  <= last_idx_next;
    end else if (s_accept) begin
      if (in_flags.last_col) begin
        col_count <= '0;
        // wrap to a new frame after the bottom-right pixel
        row_count <= in_flags.last_row ? '0 : row_count + CNT_W'(1);
      end else begin
        col_count <= col_count + CNT_W'(1);
      end
    end
  end

  // consecutive pixels always hit different columns, so a read never meets
  // a write to the same entry in flight
  bb3_line_store #(
    .DEPTH  (MAX_DIM),
    .ADDR_W (CNT_W)
  ) u_line_store (
    .clk       (clk),
    .rd_en     (s_accept),
    .rd_addr   (col_count),
    .rd_older  (rd_older),
    .rd_recent (rd_recent),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_older  (wr_older),
    .wr_recent (wr_recent)
  );

  bb3_window #(
    .CNT_W (CNT_W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_accept),
    .pix       (in_pix),
    .row       (row_count),
    .col       (col_count),
    .flags     (in_flags),
    .ready     (win_ready),
    .rd_older  (rd_older),
    .rd_recent (rd_recent),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_older  (wr_older),
    .wr_recent (wr_recent),
    .job_valid (job_valid),
    .job_done  (job_done),
    .job_top   (job_top),
    .job_bot   (job_bot),
    .job_flags (job_flags),
    .job_row   (job_row),
    .job_col   (job_col)
  );

  bb3_emitter #(
    .CNT_W (CNT_W)
  ) u_emitter (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_done  (job_done),
    .job_top   (job_top),
    .job_bot   (job_bot),
    .job_flags (job_flags),
    .job_row   (job_row),
    .job_col   (job_col),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_sum   (res_sum),
    .res_ctl   (res_ctl)
  );

  bb3_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_sum   (res_sum),
    .res_ctl   (res_ctl),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

/* rtl/core/bb3_line_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_line_store
// Two row memories sharing one address: the row above and the row two above.
// ----------------------------------------------------------------------------
module bb3_line_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire                 clk,
  input  wire                 rd_en,
  input  wire  [ADDR_W-1:0]   rd_addr,
  output bb3_pkg::pix_t       rd_older,
  output bb3_pkg::pix_t       rd_recent,
  input  wire                 wr_en,
  input  wire  [ADDR_W-1:0]   wr_addr,
  input  bb3_pkg::pix_t       wr_older,
  input  bb3_pkg::pix_t       wr_recent
);

  bb3_pkg::pix_t older_mem  [DEPTH];
  bb3_pkg::pix_t recent_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr]  <= wr_older;
      recent_mem[wr_addr] <= wr_recent;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_older  <= older_mem[rd_addr];
      rd_recent <= recent_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bb3_window.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_window
// Read stage and 3x3 window: writes the rows back and forms column sums.
// ----------------------------------------------------------------------------
module bb3_window #(
  parameter int CNT_W = 10
) (
  input  wire                   clk,
  input  wire                   rst,
  // accepted pixel, row store read issued in the same cycle
  input  wire                   accept,
  input  bb3_pkg::pix_t         pix,
  input  wire  [CNT_W-1:0]      row,
  input  wire  [CNT_W-1:0]      col,
  input  bb3_pkg::win_flags_t   flags,
  output logic                  ready,
  // row store
  input  bb3_pkg::pix_t         rd_older,
  input  bb3_pkg::pix_t         rd_recent,
  output logic                  wr_en,
  output logic [CNT_W-1:0]      wr_addr,
  output bb3_pkg::pix_t         wr_older,
  output bb3_pkg::pix_t         wr_recent,
  // column sums of one window
  output logic                  job_valid,
  input  wire                   job_done,
  output bb3_pkg::vsum_t        job_top [3],
  output bb3_pkg::vsum_t        job_bot [3],
  output bb3_pkg::win_flags_t   job_flags,
  output logic [CNT_W-1:0]      job_row,
  output logic [CNT_W-1:0]      job_col
);

  logic                s1_valid;
  bb3_pkg::pix_t       s1_pix;
  logic [CNT_W-1:0]    s1_row;
  logic [CNT_W-1:0]    s1_col;
  bb3_pkg::win_flags_t s1_flags;
  logic                s1_adv;
  logic                job_load;

  // previous two columns, indexed by row (0 = two above, 2 = current)
  bb3_pkg::pix_t win1 [3];
  bb3_pkg::pix_t win2 [3];

  bb3_pkg::pix_t  cur_col [3];
  bb3_pkg::pix_t  grid    [3][3];   // [column][row]
  bb3_pkg::vsum_t top_next [3];
  bb3_pkg::vsum_t bot_next [3];

  // items with no result do not need the job slot
  assign s1_adv   = s1_valid && (!s1_flags.has_out || !job_valid || job_done);
  assign ready    = !s1_valid || s1_adv;
  // only items with a result take the job slot, a pending job stays put
  assign job_load = s1_adv && s1_flags.has_out;

  always_comb begin
    cur_col[0] = rd_older;
    cur_col[1] = rd_recent;
    cur_col[2] = s1_pix;
    for (int ri = 0; ri < 3; ri++) begin
      grid[0][ri] = win2[ri];
      grid[1][ri] = win1[ri];
      grid[2][ri] = cur_col[ri];
    end
    for (int k = 0; k < 3; k++) begin
      bot_next[k] = bb3_pkg::pix_pair_sum(grid[k][1], grid[k][2]);
      top_next[k] = s1_flags.top_clip ? bot_next[k]
                                      : bb3_pkg::vsum_pix_add(bot_next[k], grid[k][0]);
    end
  end

  // write back: the row above moves down, the new pixel becomes the row above
  assign wr_en     = s1_adv;
  assign wr_addr   = s1_col;
  assign wr_older  = rd_recent;
  assign wr_recent = s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (job_load) begin
        job_valid <= 1'b1;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= pix;
      s1_row   <= row;
      s1_col   <= col;
      s1_flags <= flags;
    end
    if (s1_adv) begin
      for (int ri = 0; ri < 3; ri++) begin
        win2[ri] <= win1[ri];
        win1[ri] <= cur_col[ri];
      end
    end
    if (job_load) begin
      for (int k = 0; k < 3; k++) begin
        job_top[k] <= top_next[k];
        job_bot[k] <= bot_next[k];
      end
      job_flags <= s1_flags;
      job_row   <= s1_row;
      job_col   <= s1_col;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bb3_emitter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_emitter
// Walks the one to four results of a window and adds the column sums.
// ----------------------------------------------------------------------------
module bb3_emitter #(
  parameter int CNT_W = 10
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   job_valid,
  output logic                  job_done,
  input  bb3_pkg::vsum_t        job_top [3],
  input  bb3_pkg::vsum_t        job_bot [3],
  input  bb3_pkg::win_flags_t   job_flags,
  input  wire  [CNT_W-1:0]      job_row,
  input  wire  [CNT_W-1:0]      job_col,
  output logic                  res_valid,
  input  wire                   res_ready,
  output bb3_pkg::hsum_t        res_sum,
  output bb3_pkg::res_ctl_t     res_ctl
);

  // result order: above row, last row, then the same two for the last column
  logic [3:0] present;
  logic [3:0] done;
  logic [3:0] remaining;
  logic [3:0] cur;
  logic       emit;
  logic       final_res;
  logic       use_bot;
  logic       right_edge;
  logic       narrow;
  logic       rows3;
  logic       cols3;

  logic [CNT_W-1:0]       row_sel;
  logic [CNT_W-1:0]       col_sel;
  logic [CNT_W+bb3_pkg::POS_W-1:0] row_ext;
  logic [CNT_W+bb3_pkg::POS_W-1:0] col_ext;
  bb3_pkg::vsum_t         vs [3];
  bb3_pkg::hsum_t         sum_next;
  bb3_pkg::res_ctl_t      ctl_next;

  always_comb begin
    present   = {job_flags.last_row && job_flags.last_col, job_flags.last_col,
                 job_flags.last_row, 1'b1};
    remaining = present & ~done;
    cur       = remaining & (~remaining + 4'd1);
    final_res = (remaining & ~cur) == 4'd0;
    emit      = job_valid && (!res_valid || res_ready);
    job_done  = emit && final_res;

    use_bot    = cur[1] || cur[3];
    right_edge = cur[2] || cur[3];
    narrow     = right_edge || job_flags.left_clip;
    rows3      = !use_bot && !job_flags.top_clip;
    cols3      = !narrow;

    for (int k = 0; k < 3; k++) begin
      vs[k] = use_bot ? job_bot[k] : job_top[k];
    end
    sum_next = bb3_pkg::hsum_of(vs[2], vs[1], vs[0], cols3);

    row_sel = use_bot ? job_row : job_row - CNT_W'(1);
    col_sel = right_edge ? job_col : job_col - CNT_W'(1);
    row_ext = {{bb3_pkg::POS_W{1'b0}}, row_sel};
    col_ext = {{bb3_pkg::POS_W{1'b0}}, col_sel};

    if (rows3 && cols3) begin
      ctl_next.area = bb3_pkg::AREA_9;
    end else if (!rows3 && !cols3) begin
      ctl_next.area = bb3_pkg::AREA_4;
    end else begin
      ctl_next.area = bb3_pkg::AREA_6;
    end
    ctl_next.row  = row_ext[bb3_pkg::POS_W-1:0];
    ctl_next.col  = col_ext[bb3_pkg::POS_W-1:0];
    ctl_next.last = final_res;
    ctl_next.eof  = cur[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 4'd0;
      res_valid <= 1'b0;
    end else begin
      if (job_done) begin
        done <= 4'd0;
      end else if (emit) begin
        done <= done | cur;
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_sum <= sum_next;
      res_ctl <= ctl_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bb3_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_divider
// Output register: divides each channel sum by the window area.
// ----------------------------------------------------------------------------
module bb3_divider (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          res_valid,
  output logic                         res_ready,
  input  bb3_pkg::hsum_t               res_sum,
  input  bb3_pkg::res_ctl_t            res_ctl,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [bb3_pkg::OUT_W-1:0]    m_tdata,
  output logic                         m_tlast,
  output logic                         m_tuser
);

  localparam int PAD_W = bb3_pkg::OUT_W - 3 * bb3_pkg::CH_W - 2 * bb3_pkg::POS_W;

  logic                    load;
  logic [bb3_pkg::CH_W-1:0] mean_red;
  logic [bb3_pkg::CH_W-1:0] mean_green;
  logic [bb3_pkg::CH_W-1:0] mean_blue;

  assign res_ready = !m_tvalid || m_tready;
  assign load      = res_valid && res_ready;

  always_comb begin
    mean_red   = bb3_pkg::area_mean(res_sum.red,   res_ctl.area);
    mean_green = bb3_pkg::area_mean(res_sum.green, res_ctl.area);
    mean_blue  = bb3_pkg::area_mean(res_sum.blue,  res_ctl.area);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {{PAD_W{1'b0}}, res_ctl.col, res_ctl.row,
                  mean_blue, mean_green, mean_red};
      m_tlast <= res_ctl.last;
      m_tuser <= res_ctl.eof;
    end
  end

endmodule
`default_nettype wire

/* verif/tb_box_blur_3x3_rgb.sv */
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb
// Self-checking bench for the 3x3 rgb box blur. Pixels go in at random pace.
// A predictor with its own row stores and window columns works out every
// smoothed pixel, with its row, column, tlast and tuser. Each output beat is
// compared with the oldest predicted pixel. The image size is rewritten
// between phases, including clamped, largest and mid-frame writes.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb;

  localparam int MAX_SIDE      = 1024;
  localparam int RANDOM_PIXELS = 360;
  localparam int DRAIN_CYCLES  = 12;     // extra wait after the last expected result
  localparam int IDLE_LIMIT    = 4000;   // cycles with no beat on any channel
  localparam int REPORT_MAX    = 10;

  // output tdata layout, highest field first
  typedef struct packed {
    logic [3:0]                pad;
    logic [bb3_pkg::POS_W-1:0] col;
    logic [bb3_pkg::POS_W-1:0] row;
    bb3_pkg::pix_t             px;
  } blur_beat_t;

  typedef struct packed {
    bb3_pkg::pix_t             px;
    logic [bb3_pkg::POS_W-1:0] row;
    logic [bb3_pkg::POS_W-1:0] col;
    logic                      last;
    logic                      eof;
  } mean_px_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [bb3_pkg::CFG_W-1:0] cfg_data  = '0;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  bb3_pkg::pix_t             s_tdata   = '0;
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [bb3_pkg::OUT_W-1:0] m_tdata;
  logic                      m_tlast;
  logic                      m_tuser;

  always #1 clk = ~clk;

  box_blur_3x3_rgb #(.MAX_DIM(MAX_SIDE)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // predictor state
  bb3_pkg::pix_t             recent_row [MAX_SIDE];
  bb3_pkg::pix_t             older_row  [MAX_SIDE];
  bb3_pkg::pix_t             cur_col    [3];      // rows r-2, r-1, r at column c
  bb3_pkg::pix_t             prev_col   [3];      // column c-1
  bb3_pkg::pix_t             prev2_col  [3];      // column c-2
  int unsigned               pos_row    = 0;
  int unsigned               pos_col    = 0;
  logic [bb3_pkg::CFG_W-1:0] side_reg   = bb3_pkg::CFG_RESET;

  mean_px_t         pending_means [$];

  int               pace         = 1;    // 0: both sides run without gaps
  int               stall_left   = 0;
  int               errors       = 0;
  int               reported     = 0;
  int               pixels_sent  = 0;
  int               means_seen   = 0;
  int               size_writes  = 0;
  int               idle_cycles  = 0;

  blur_beat_t       beat;
  assign beat = m_tdata;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (pace == 0 || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned eff_side();
    if (side_reg < 2) return 2;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return side_reg;
  endfunction

  // truncated mean over rows top..2 and columns left..2 of the window
  function automatic mean_px_t window_mean(int unsigned top, int unsigned left,
                                           int unsigned orow, int unsigned ocol,
                                           logic eof);
    int unsigned   sr, sg, sb, cnt;
    bb3_pkg::pix_t p;
    mean_px_t      res;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int ri = top; ri < 3; ri++) begin
      for (int ci = left; ci < 3; ci++) begin
        p = (ci == 2) ? cur_col[ri] : (ci == 1) ? prev_col[ri] : prev2_col[ri];
        sr += p.red;
        sg += p.green;
        sb += p.blue;
        cnt++;
      end
    end
    if (cnt == 4) begin
      res.px.red = 16'(sr >> 2); res.px.green = 16'(sg >> 2); res.px.blue = 16'(sb >> 2);
    end else if (cnt == 6) begin
      res.px.red = 16'(sr / 6); res.px.green = 16'(sg / 6); res.px.blue = 16'(sb / 6);
    end else begin
      res.px.red = 16'(sr / 9); res.px.green = 16'(sg / 9); res.px.blue = 16'(sb / 9);
    end
    res.row  = bb3_pkg::POS_W'(orow);
    res.col  = bb3_pkg::POS_W'(ocol);
    res.last = 1'b0;
    res.eof  = eof;
    return res;
  endfunction

  // expected smoothed pixels caused by one accepted input pixel
  function automatic void predict_blur(bb3_pkg::pix_t p);
    int unsigned n, r, c, top, left;
    logic        lrow, lcol;
    mean_px_t    res [$];
    n    = eff_side();
    r    = pos_row;
    c    = pos_col;
    top  = (r >= 2) ? 0 : 1;
    left = (c >= 2) ? 0 : 1;
    lrow = (r == n - 1);
    lcol = (c == n - 1);
    cur_col[0] = older_row[c];
    cur_col[1] = recent_row[c];
    cur_col[2] = p;
    if (r >= 1 && c >= 1) begin
      res.push_back(window_mean(top, left, r - 1, c - 1, 1'b0));
      // last row: its own pixel follows each pixel of the row above
      if (lrow) res.push_back(window_mean(1, left, r, c - 1, 1'b0));
      if (lcol) begin
        res.push_back(window_mean(top, 1, r - 1, c, 1'b0));
        if (lrow) res.push_back(window_mean(1, 1, r, c, 1'b1));
      end
      res[res.size() - 1].last = 1'b1;
      foreach (res[i]) pending_means.push_back(res[i]);
    end
    for (int i = 0; i < 3; i++) begin
      prev2_col[i] = prev_col[i];
      prev_col[i]  = cur_col[i];
    end
    older_row[c]  = recent_row[c];
    recent_row[c] = p;
    if (lcol) begin
      pos_col = 0;
      pos_row = lrow ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
  endfunction

  function automatic bb3_pkg::pix_t rand_pixel();
    bb3_pkg::pix_t p;
    case ($urandom_range(0, 9))
      0: p = '1;
      1: p = '0;
      2: begin
        p.red   = {16{1'($urandom_range(0, 1))}};
        p.green = {16{1'($urandom_range(0, 1))}};
        p.blue  = {16{1'($urandom_range(0, 1))}};
      end
      default: begin
        p.red   = 16'($urandom);
        p.green = 16'($urandom);
        p.blue  = 16'($urandom);
      end
    endcase
    return p;
  endfunction

  task automatic send_pixel(input bb3_pkg::pix_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    do @(posedge clk); while (!s_tready);
    predict_blur(p);
    pixels_sent++;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel());
  endtask

  // stop the pixel stream, let every pending result out, then a few more cycles
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [bb3_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    side_reg = value;
    pos_row  = 0;
    pos_col  = 0;
    size_writes++;
  endtask

  // ---------------------------------------------------------------- tests

  // reset size of 512: part of row 0, which gives no results
  task automatic test_default_size();
    send_random(24);
  endtask

  // full-scale sums for the 4, 6 and 9 pixel windows, then alternating extremes
  task automatic test_extreme_values();
    bb3_pkg::pix_t p;
    pace = 0;
    write_size(11'd3);
    for (int i = 0; i < 9; i++) send_pixel('1);
    write_size(11'd2);
    for (int i = 0; i < 4; i++) begin
      p.red   = (i % 2) ? 16'hFFFF : 16'h0000;
      p.green = (i % 2) ? 16'h0000 : 16'hFFFF;
      p.blue  = (i < 2) ? 16'hFFFF : 16'h0001;
      send_pixel(p);
    end
    pace = 1;
  endtask

  // sizes 0 and 1 behave as 2
  task automatic test_clamped_sizes();
    write_size(11'd0);
    send_random(4);
    write_size(11'd1);
    send_random(4);
  endtask

  // a size write part way into a frame restarts at row 0 column 0
  task automatic test_restart_mid_frame();
    write_size(11'd4);
    send_random(6);
    write_size(11'd5);
    send_random(25);
    send_random(7);           // next frame after the wrap, cut short
  endtask

  // largest size, and the top of the register field which acts as the largest;
  // the start of a wide first row gives no results
  task automatic test_largest_sizes();
    write_size(11'd1024);
    send_random(16);
    write_size(11'd2047);
    send_random(16);
  endtask

  // random square frames, some cut short, some run back to back
  task automatic test_random_frames();
    int          start;
    int unsigned n, total, remaining;
    logic        broken;
    logic [bb3_pkg::CFG_W-1:0] pick;
    start  = pixels_sent;
    broken = 1'b1;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      if (broken || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 19))
          0:       pick = bb3_pkg::CFG_W'($urandom_range(0, 1));
          1, 2, 3: pick = bb3_pkg::CFG_W'($urandom_range(9, 16));
          default: pick = bb3_pkg::CFG_W'($urandom_range(2, 8));
        endcase
        write_size(pick);
      end
      pace   = ($urandom_range(0, 3) != 0);
      n      = eff_side();
      total  = n * n;
      broken = ($urandom_range(0, 6) == 0);
      if (broken) total = $urandom_range(1, total - 1);
      remaining = RANDOM_PIXELS - (pixels_sent - start);
      if (total > remaining) total = remaining;
      send_random(total);
    end
    pace = 1;
  endtask

  // ------------------------------------------------------- output side

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    mean_px_t want;
    if (!rst && m_tvalid && m_tready) begin
      means_seen++;
      if (pending_means.size() == 0) begin
        errors++;
        if (reported < REPORT_MAX) begin
          $display("unexpected beat: row %0d col %0d rgb %h %h %h", beat.row, beat.col,
                   beat.px.red, beat.px.green, beat.px.blue);
          reported++;
        end
      end else begin
        want = pending_means.pop_front();
        if (beat.px.red !== want.px.red || beat.px.green !== want.px.green ||
            beat.px.blue !== want.px.blue || beat.row !== want.row ||
            beat.col !== want.col || m_tlast !== want.last || m_tuser !== want.eof) begin
          errors++;
          if (reported < REPORT_MAX) begin
            $display("mismatch at (%0d,%0d): exp rgb %h %h %h row %0d col %0d last %b eof %b",
                     want.row, want.col, want.px.red, want.px.green, want.px.blue,
                     want.row, want.col, want.last, want.eof);
            $display("                    got rgb %h %h %h row %0d col %0d last %b eof %b",
                     beat.px.red, beat.px.green, beat.px.blue,
                     beat.row, beat.col, m_tlast, m_tuser);
            reported++;
          end
        end
      end
    end
  end

  // watchdog: no beat on any channel for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_means.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_size();
    test_extreme_values();
    test_clamped_sizes();
    test_restart_mid_frame();
    test_largest_sizes();
    test_random_frames();
    wait_idle();
    if (pending_means.size() != 0) errors += pending_means.size();
    $display("summary: %0d pixels in, %0d smoothed pixels checked, %0d size writes",
             pixels_sent, means_seen, size_writes);
    $display("summary: sizes 0..16, 512, 1024 and 2047, cut and wrapped frames, %0d errors",
             errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
